// ===== rtl/rmsdb_pkg.sv =====
// Shared constants and types for the RMS level meter.
// No dependencies; every other file of the block imports this package.
package rmsdb_pkg;

  localparam int unsigned SAMPLE_W      = 16;
  localparam int unsigned RMS_W         = 24;
  localparam int unsigned DB_W          = 16;
  localparam int unsigned MEAN_W        = 48;
  localparam int unsigned FRAC_W        = 16;
  localparam int unsigned EXP_W         = 5;
  localparam int unsigned DEF_MAX_BLOCK = 4096;

  localparam logic signed [DB_W-1:0] DB_FLOOR_Q8 = -16'sd25600;
  // 20*log10(2) in Q16.
  localparam logic signed [20:0] TWENTY_LOG10_2_Q16 = 21'sd394566;
  // log2(256) in Q16, removes the eight fraction bits of the RMS value.
  localparam logic signed [21:0] LOG_OFFSET_Q16 = 22'sd524288;

  typedef struct packed {
    logic [RMS_W-1:0]       rms;
    logic signed [DB_W-1:0] db;
  } level_t;

endpackage

// ===== rtl/rmsdb_acc.sv =====
// Sum-of-squares accumulator with a saturating sample count.
// Depends on rmsdb_pkg.
module rmsdb_acc #(
  parameter int unsigned MAX_BLOCK_SAMPLES = rmsdb_pkg::DEF_MAX_BLOCK,
  parameter int unsigned CW = $clog2(MAX_BLOCK_SAMPLES + 1),
  parameter int unsigned SW = 30 + CW
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  logic signed [rmsdb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                last_i,
  output logic [SW-1:0]                       sum_o,
  output logic [CW-1:0]                       cnt_o,
  output logic                                ovf_o,
  output logic                                end_o
);
  import rmsdb_pkg::*;

  logic [SW-1:0]      sum_q, sum_d, snap_sum_q;
  logic [CW-1:0]      cnt_q, cnt_d, snap_cnt_q;
  logic               ovf_q, ovf_d, snap_ovf_q, end_q;
  logic signed [31:0] sq;

  assign sq = sample_i * sample_i;

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cnt_q < CW'(MAX_BLOCK_SAMPLES)) begin
      sum_d = sum_q + {{(SW-31){1'b0}}, sq[30:0]};
      cnt_d = cnt_q + 1'b1;
    end else begin
      ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      end_q <= 1'b0;
    end else begin
      end_q <= fire_i && last_i;
      if (fire_i) begin
        if (last_i) begin
          sum_q <= '0;
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          sum_q <= sum_d;
          cnt_q <= cnt_d;
          ovf_q <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i && last_i) begin
      snap_sum_q <= sum_d;
      snap_cnt_q <= cnt_d;
      snap_ovf_q <= ovf_d;
    end
  end

  assign sum_o = snap_sum_q;
  assign cnt_o = snap_cnt_q;
  assign ovf_o = snap_ovf_q;
  assign end_o = end_q;

endmodule

// ===== rtl/rmsdb_div.sv =====
// Bit-serial restoring divider: (sum * 65536) / count, one quotient bit a cycle.
// Depends on rmsdb_pkg.
module rmsdb_div #(
  parameter int unsigned CW = 13,
  parameter int unsigned SW = 43
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [SW-1:0]                  sum_i,
  input  logic [CW-1:0]                  cnt_i,
  output logic [rmsdb_pkg::MEAN_W-1:0]   mean_o,
  output logic                           done_o
);
  import rmsdb_pkg::*;

  localparam int unsigned DW  = SW + FRAC_W;
  localparam int unsigned STW = $clog2(DW + 1);

  logic [DW-1:0]  q_q;
  logic [CW-1:0]  rem_q, div_q;
  logic [STW-1:0] step_q;
  logic           busy_q, done_q;
  logic [CW:0]    shifted;
  logic           ge;

  assign shifted = {rem_q, q_q[DW-1]};
  assign ge      = shifted >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STW'(DW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == STW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= {sum_i, {FRAC_W{1'b0}}};
      rem_q <= '0;
      div_q <= cnt_i;
    end else if (busy_q) begin
      q_q   <= {q_q[DW-2:0], ge};
      rem_q <= ge ? CW'(shifted - {1'b0, div_q}) : shifted[CW-1:0];
    end
  end

  // An empty count cannot occur, but it is mapped to a zero mean all the same.
  assign mean_o = (div_q == '0) ? '0 : MEAN_W'(q_q);
  assign done_o = done_q;

endmodule

// ===== rtl/rmsdb_sqrt.sv =====
// Digit-serial integer square root, two radicand bits a cycle.
// Depends on rmsdb_pkg.
module rmsdb_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rmsdb_pkg::MEAN_W-1:0] rad_i,
  output logic [rmsdb_pkg::RMS_W-1:0]  root_o,
  output logic                         done_o
);
  import rmsdb_pkg::*;

  localparam int unsigned REM_W = RMS_W + 3;

  logic [MEAN_W-1:0] rad_q;
  logic [REM_W-1:0]  rem_q, shifted, trial;
  logic [RMS_W-1:0]  root_q;
  logic [4:0]        step_q;
  logic              busy_q, done_q, ge;

  assign shifted = {rem_q[REM_W-3:0], rad_q[MEAN_W-1:MEAN_W-2]};
  assign trial   = {2'b00, root_q[RMS_W-2:0], 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= 5'(RMS_W);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[MEAN_W-3:0], 2'b00};
      rem_q  <= ge ? shifted - trial : shifted;
      root_q <= {root_q[RMS_W-2:0], ge};
    end
  end

  assign root_o = root_q;
  assign done_o = done_q;

endmodule

// ===== rtl/rmsdb_log.sv =====
// Decibel conversion: serial leading-one search, log2 fraction by repeated
// squaring, then scaling by 20*log10(2). Depends on rmsdb_pkg.
module rmsdb_log (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rmsdb_pkg::RMS_W-1:0] rms_i,
  output rmsdb_pkg::level_t           level_o,
  output logic                        done_o
);
  import rmsdb_pkg::*;

  localparam logic [2:0] L_IDLE = 3'd0;
  localparam logic [2:0] L_NORM = 3'd1;
  localparam logic [2:0] L_MUL  = 3'd2;
  localparam logic [2:0] L_ADJ  = 3'd3;
  localparam logic [2:0] L_DBM  = 3'd4;
  localparam logic [2:0] L_OUT  = 3'd5;

  logic [2:0]         st_q;
  logic [RMS_W-1:0]   x_q, rms_q;
  logic [EXP_W-1:0]   e_q;
  logic [30:0]        m_q;
  logic [61:0]        p_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [4:0]         it_q;
  logic signed [41:0] v_q;
  logic signed [41:0] v_rnd;
  logic signed [21:0] d;
  logic [31:0]        t;
  logic               done_q;
  level_t             lvl_q;

  assign t     = p_q[61:30];
  assign d     = $signed({1'b0, e_q, frac_q}) - LOG_OFFSET_Q16;
  assign v_rnd = v_q + 42'sd8388608;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (st_q)
        L_IDLE: if (start_i) st_q <= (rms_i == '0) ? L_OUT : L_NORM;
        L_NORM: if (x_q[RMS_W-1]) st_q <= L_MUL;
        L_MUL:  st_q <= L_ADJ;
        L_ADJ:  st_q <= (it_q == 5'd1) ? L_DBM : L_MUL;
        L_DBM:  st_q <= L_OUT;
        L_OUT: begin
          st_q   <= L_IDLE;
          done_q <= 1'b1;
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      L_IDLE: begin
        x_q   <= rms_i;
        rms_q <= rms_i;
        e_q   <= EXP_W'(RMS_W - 1);
      end
      L_NORM: begin
        if (x_q[RMS_W-1]) begin
          m_q    <= {x_q, 7'b0};
          it_q   <= 5'(FRAC_W);
          frac_q <= '0;
        end else begin
          x_q <= {x_q[RMS_W-2:0], 1'b0};
          e_q <= e_q - 1'b1;
        end
      end
      L_MUL: p_q <= m_q * m_q;
      L_ADJ: begin
        // A squared mantissa of two or more yields a one bit and is halved.
        m_q    <= t[31] ? t[31:1] : t[30:0];
        frac_q <= {frac_q[FRAC_W-2:0], t[31]};
        it_q   <= it_q - 1'b1;
      end
      L_DBM: v_q <= d * TWENTY_LOG10_2_Q16;
      L_OUT: begin
        lvl_q.rms <= rms_q;
        lvl_q.db  <= (rms_q == '0) ? DB_FLOOR_Q8 : v_rnd[39:24];
      end
      default: ;
    endcase
  end

  assign level_o = lvl_q;
  assign done_o  = done_q;

endmodule

// ===== rtl/block_rms_db_level_meter_core.sv =====
// RMS level meter in decibels, top level.
// Depends on rmsdb_pkg, rmsdb_acc, rmsdb_div, rmsdb_sqrt and rmsdb_log.
//
// Input channel (sample_i, last_i) takes one word per cycle while the block
// is accumulating; each sample up to MAX_BLOCK_SAMPLES adds its square to the
// running sum. The word with last_i high closes the block and starts the
// block-end computation, during which in_ready_o is low. That computation is
// serial: the divider, then the square root, then the dB conversion with its
// leading-one search, mantissa squaring and scaling. A zero RMS skips the
// leading-one search and the squaring.
// The result word (rms_level_o, level_db_o, block_overflow_o) sits in an
// output register; accumulation of the next block resumes as soon as the
// result is loaded there, even while the receiver stalls. If the previous
// result is still unread when a new one is ready, the block waits.
// Reset clears the sum, the count, the overflow flag and the output valid flag.
module block_rms_db_level_meter_core #(
  parameter int unsigned MAX_BLOCK_SAMPLES = rmsdb_pkg::DEF_MAX_BLOCK
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [rmsdb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 last_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [rmsdb_pkg::RMS_W-1:0]          rms_level_o,
  output logic signed [rmsdb_pkg::DB_W-1:0]    level_db_o,
  output logic                                 block_overflow_o
);
  import rmsdb_pkg::*;

  localparam int unsigned CW = $clog2(MAX_BLOCK_SAMPLES + 1);
  localparam int unsigned SW = 30 + CW;

  localparam logic [1:0] S_ACC  = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]        st_q;
  logic              in_fire, acc_end, div_done, sqrt_done, log_done, ovf;
  logic              load, out_valid_q;
  logic [SW-1:0]     sum;
  logic [CW-1:0]     cnt;
  logic [MEAN_W-1:0] mean;
  logic [RMS_W-1:0]  root;
  level_t            lvl, out_lvl_q;
  logic              out_ovf_q;

  assign in_ready_o = (st_q == S_ACC);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load       = (st_q == S_WAIT) && (!out_valid_q || out_ready_i);

  rmsdb_acc #(.MAX_BLOCK_SAMPLES(MAX_BLOCK_SAMPLES), .CW(CW), .SW(SW)) u_acc (
    .clk_i, .rst_ni, .fire_i(in_fire), .sample_i, .last_i,
    .sum_o(sum), .cnt_o(cnt), .ovf_o(ovf), .end_o(acc_end)
  );

  rmsdb_div #(.CW(CW), .SW(SW)) u_div (
    .clk_i, .rst_ni, .start_i(acc_end), .sum_i(sum), .cnt_i(cnt),
    .mean_o(mean), .done_o(div_done)
  );

  rmsdb_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(div_done), .rad_i(mean),
    .root_o(root), .done_o(sqrt_done)
  );

  rmsdb_log u_log (
    .clk_i, .rst_ni, .start_i(sqrt_done), .rms_i(root),
    .level_o(lvl), .done_o(log_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      case (st_q)
        S_ACC:  if (in_fire && last_i) st_q <= S_CALC;
        S_CALC: if (log_done) st_q <= S_WAIT;
        S_WAIT: if (load) st_q <= S_ACC;
        default: st_q <= S_ACC;
      endcase
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_lvl_q <= lvl;
      out_ovf_q <= ovf;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign rms_level_o      = out_lvl_q.rms;
  assign level_db_o       = out_lvl_q.db;
  assign block_overflow_o = out_ovf_q;

  a_last_starts_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && last_i |=> st_q == S_CALC)
    else $error("closing word did not start the block-end computation");

  a_log_only_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> st_q == S_CALC)
    else $error("dB result arrived outside the computation phase");

  a_load_resumes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o && st_q == S_ACC)
    else $error("result load did not present a word and resume accumulation");

  a_zero_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rms_level_o == '0 |-> level_db_o == DB_FLOOR_Q8)
    else $error("zero RMS without the dB floor");

endmodule
